// ----- src/smt_pkg.sv -----
// sorted multiset table: shared constants and the cell command type
// no dependencies; used by the top level and by the cell
`timescale 1ns / 1ps

package smt_pkg;

   // default number of table entries
   localparam int TABLE_DEPTH = 16;

   // width of one stored value and of the result occupancy field
   localparam int VALUE_W = 32;
   localparam int OCC_W   = 5;

   // request kinds carried on req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic                      capture; // register compare flags against value
      logic                      insert;  // open a slot at the boundary and write value
      logic                      remove;  // close the slot at the boundary
      logic                      found;   // boundary cell matched the value
      logic signed [VALUE_W-1:0] value;   // request operand
   } cell_cmd_type;

endpackage

// ----- src/sorted_multiset_table_top.sv -----
// sorted multiset table: controller, result register and the chain of cells
// depends on smt_pkg and smt_cell
`timescale 1ns / 1ps

//  channel | ports      | tdata (low bit up)                         | tuser
//  request | req_t*     | value[31:0]                                | operation
//  result  | rsp_t*     | ok, occupancy[4:0], is_empty, smallest[31:0], zero fill to 40 | none
//
// each request has two steps: in the accept cycle every cell compares its entry
// with the operand; in the update state every cell shifts by one place at once
// a new request is taken the cycle after the update, while the result waits
// the update cycle waits while the result register is still full and stalled
// reset empties the table; the stored values are left as they are

module sorted_multiset_table_top #(
   parameter int TABLE_DEPTH = smt_pkg::TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // ok, occupancy[4:0], is_empty, smallest[31:0], zero fill
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int VW = smt_pkg::VALUE_W;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  op_ff;
   logic signed [VW-1:0]  operand_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  ok_ff;
   logic                  ok_in;
   logic [CW+4:0]         count_wide;
   logic signed [VW-1:0]  smallest_ff;
   logic signed [VW-1:0]  smallest_in;
   logic                  accept;
   logic                  commit;
   logic                  full;
   logic                  found;
   smt_pkg::cell_cmd_type cmd;

   logic [TABLE_DEPTH-1:0]        lt_vec;
   logic [TABLE_DEPTH-1:0]        hit_vec;
   logic signed [VW-1:0]          entry_vec [TABLE_DEPTH];
   logic signed [VW-1:0]          next_vec  [TABLE_DEPTH];

   // handshake and update strobes
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign full       = (count_ff == CW'(TABLE_DEPTH));
   assign found      = |hit_vec;

   // command broadcast to the cells
   always_comb begin
      cmd.capture = accept;
      cmd.insert  = commit && (op_ff == smt_pkg::OP_INSERT) && !full;
      cmd.remove  = commit && (op_ff == smt_pkg::OP_REMOVE);
      cmd.found   = found;
      cmd.value   = (state_ff == S_IDLE) ? $signed(req_tdata[VW-1:0]) : operand_ff;
   end

   // chain of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                 left_lt;
      logic signed [VW-1:0] left_entry;
      logic signed [VW-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_entry = operand_ff;
      end else begin : g_body
         assign left_lt    = lt_vec[i-1];
         assign left_entry = entry_vec[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_entry = entry_vec[i];
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end

      smt_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .update      (commit),
         .count       (count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .lt          (lt_vec[i]),
         .hit         (hit_vec[i]),
         .entry       (entry_vec[i]),
         .entry_next  (next_vec[i])
      );
   end

   // next state, count and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      smallest_in  = smallest_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (commit) begin
               if (cmd.insert) begin
                  count_in = count_ff + 1'b1;
               end else if (cmd.remove && found) begin
                  count_in = count_ff - 1'b1;
               end
               ok_in        = cmd.insert || (cmd.remove && found);
               smallest_in  = (count_in == '0) ? '0 : next_vec[0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         op_ff      <= req_tuser[0];
         operand_ff <= $signed(req_tdata[VW-1:0]);
      end
      ok_ff       <= ok_in;
      smallest_ff <= smallest_in;
   end

   // result packing; occupancy wraps modulo 32 for deep tables
   assign count_wide = {5'b0, count_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, smallest_ff, (count_ff == '0),
                        count_wide[smt_pkg::OCC_W-1:0], ok_ff};

endmodule

// ----- src/smt_cell.sv -----
// sorted multiset table: one cell of the sorted chain
// depends on smt_pkg
`timescale 1ns / 1ps

module smt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                                clock,
   input  smt_pkg::cell_cmd_type               cmd,
   input  logic                                update,
   input  logic [CW-1:0]                       count,
   input  logic                                left_lt,
   input  logic signed [smt_pkg::VALUE_W-1:0]  left_entry,
   input  logic signed [smt_pkg::VALUE_W-1:0]  right_entry,
   output logic                                lt,
   output logic                                hit,
   output logic signed [smt_pkg::VALUE_W-1:0]  entry,
   output logic signed [smt_pkg::VALUE_W-1:0]  entry_next
);

   logic                               occupied;
   logic                               lt_ff;
   logic                               lt_in;
   logic                               eq_ff;
   logic                               eq_in;
   logic signed [smt_pkg::VALUE_W-1:0] entry_ff;
   logic signed [smt_pkg::VALUE_W-1:0] entry_in;

   // compare the stored entry against the broadcast operand
   always_comb begin
      occupied = (count > CW'(INDEX));
      lt_in    = occupied && (entry_ff < cmd.value);
      eq_in    = occupied && (entry_ff == cmd.value);
   end

   // this cell is the first one not below the operand and holds an equal value
   assign hit = left_lt && !lt_ff && eq_ff;

   // shift towards the tail on insert, towards the head on a remove that found the value
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !lt_ff) begin
         entry_in = left_lt ? cmd.value : left_entry;
      end else if (cmd.remove && cmd.found && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   // compare flags and stored value
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (update) begin
         entry_ff <= entry_in;
      end
   end

   assign lt         = lt_ff;
   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ----- src/smt_checker.sv -----
// sorted multiset table: port-level checks, bound to the top level
// depends on sorted_multiset_table_top
`timescale 1ns / 1ps

module smt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an accepted request keeps the block busy for the update cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during update");

   // an empty table reports zero as smallest
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[38:7] == 32'd0)
      else $error("empty table with non-zero smallest");

endmodule

bind sorted_multiset_table_top smt_checker u_smt_checker (.*);
